>>> sv/sbrc_pkg.sv
// Shared types and constants of the 16-bit register processor step block.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package sbrc_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_EXEC   = 2'd1;
	localparam logic [1:0] ACT_SET_PC = 2'd2;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_INP  = 4'd3;
	localparam logic [3:0] OP_LT   = 4'd4;
	localparam logic [3:0] OP_EQ   = 4'd5;
	localparam logic [3:0] OP_GT   = 4'd6;
	localparam logic [3:0] OP_NE   = 4'd7;
	localparam logic [3:0] OP_AND  = 4'd8;
	localparam logic [3:0] OP_OR   = 4'd9;
	localparam logic [3:0] OP_XOR  = 4'd10;
	localparam logic [3:0] OP_NAND = 4'd11;
	localparam logic [3:0] OP_NOR  = 4'd12;
	localparam logic [3:0] OP_XNOR = 4'd13;
	localparam logic [3:0] OP_SHL  = 4'd14;
	localparam logic [3:0] OP_SAR  = 4'd15;

	localparam logic [3:0] SRC_ONE     = 4'd9;
	localparam logic [3:0] SRC_NEG_ONE = 4'd10;

	localparam logic [2:0] REG_ZERO = 3'd0;
	localparam logic [2:0] REG_A    = 3'd4;
	localparam logic [2:0] REG_R    = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] load_address;
		logic [15:0] load_data;
	} sbrc_in_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic [15:0]        next_word;
		logic [2:0]         written_register;
		logic signed [15:0] written_value;
		logic [15:0]        store_address;
		logic [15:0]        store_data;
		logic               jump_taken;
	} sbrc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INST,
		ST_LOADR,
		ST_EXEC,
		ST_READ_PC,
		ST_RESULT
	} sbrc_state_t;

	typedef enum logic [1:0] {
		MA_PC,
		MA_LADDR,
		MA_A,
		MA_PC_NEXT
	} sbrc_addr_sel_t;

	typedef struct packed {
		logic           rd;
		sbrc_addr_sel_t sel;
		logic           load_wr;
		logic           set_pc;
		logic           latch_inst;
		logic           latch_r;
		logic           step_pc;
		logic           exec;
		logic           clear_out;
	} sbrc_cmd_t;

	typedef struct packed {
		logic is_inp;
	} sbrc_status_t;

endpackage

>>> sv/sbrc_ctrl.sv
// Sequencer of the processor step block: one state per memory access.
// Depends on sbrc_pkg.
module sbrc_ctrl
	import sbrc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   action,
	input  sbrc_status_t status,
	output logic         busy,
	output logic         done,
	output sbrc_cmd_t    cmd
);

	sbrc_state_t state_q;
	sbrc_state_t state_next;
	logic        can_accept;
	logic        accept;

	assign can_accept = (state_q == ST_IDLE) || (state_q == ST_RESULT);
	assign accept     = start && can_accept;
	assign busy       = !can_accept;
	assign done       = (state_q == ST_RESULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE, ST_RESULT: begin
				if (accept) begin
					unique case (action)
						ACT_LOAD:   state_next = ST_READ_PC;
						ACT_EXEC:   state_next = ST_INST;
						default:    state_next = ST_RESULT;
					endcase
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_INST:    state_next = ST_LOADR;
			ST_LOADR:   state_next = ST_EXEC;
			ST_EXEC:    state_next = ST_READ_PC;
			ST_READ_PC: state_next = ST_RESULT;
			default:    state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = MA_PC;
		unique case (state_q)
			ST_IDLE, ST_RESULT: begin
				if (accept) begin
					cmd.clear_out = 1'b1;
					unique case (action)
						ACT_LOAD: cmd.load_wr = 1'b1;
						ACT_SET_PC: begin
							cmd.set_pc = 1'b1;
							cmd.rd     = 1'b1;
							cmd.sel    = MA_LADDR;
						end
						default: cmd.rd = 1'b1;
					endcase
				end
			end
			ST_INST: begin
				cmd.latch_inst = 1'b1;
				cmd.rd         = 1'b1;
				cmd.sel        = MA_A;
			end
			ST_LOADR: begin
				cmd.latch_r = 1'b1;
				if (status.is_inp) begin
					cmd.rd      = 1'b1;
					cmd.sel     = MA_PC_NEXT;
					cmd.step_pc = 1'b1;
				end
			end
			ST_EXEC:    cmd.exec = 1'b1;
			ST_READ_PC: cmd.rd   = 1'b1;
			default:    cmd = '0;
		endcase
	end

endmodule

>>> sv/sbrc_dp.sv
// Datapath of the processor step block: word memory, register file, ALU,
// program counter and jump register. Depends on sbrc_pkg.
module sbrc_dp
	import sbrc_pkg::*;
#(
	parameter int MEM_WORDS = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  sbrc_cmd_t    cmd,
	input  sbrc_in_t     item,
	output sbrc_status_t status,
	output sbrc_out_t    result
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rdata_q;
	logic [15:0] regs_q [1:7];
	logic [15:0] pc_q;
	logic [15:0] jt_q;
	logic [15:0] inst_q;
	logic [15:0] op0_q;
	logic [15:0] op1_q;
	logic [2:0]  wreg_q;
	logic [15:0] wval_q;
	logic [15:0] saddr_q;
	logic [15:0] sdata_q;
	logic        jtaken_q;

	logic [2:0]    tgt;
	logic [3:0]    opc;
	logic          jbit;
	logic [15:0]   res;
	logic [15:0]   stored;
	logic [15:0]   rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_idx;
	logic [15:0]   wr_data;
	logic          branch;

	function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
		logic [31:0] r;
		r = {16'd0, a};
		for (int k = 8; k >= 0; k--) begin
			if (r >= (32'(MEM_WORDS) << k)) begin
				r = r - (32'(MEM_WORDS) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [15:0] alu(input logic [3:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] imm);
		logic [31:0] prod;
		logic [15:0] r;
		prod = 32'(a) * 32'(b);
		unique case (op)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_MUL:  r = prod[15:0];
			OP_INP:  r = imm;
			OP_LT:   r = {15'd0, $signed(a) < $signed(b)};
			OP_EQ:   r = {15'd0, a == b};
			OP_GT:   r = {15'd0, $signed(a) > $signed(b)};
			OP_NE:   r = {15'd0, a != b};
			OP_AND:  r = a & b;
			OP_OR:   r = a | b;
			OP_XOR:  r = a ^ b;
			OP_NAND: r = ~(a & b);
			OP_NOR:  r = ~(a | b);
			OP_XNOR: r = ~(a ^ b);
			OP_SHL:  r = (b >= 16'd16) ? 16'd0 : (a << b[3:0]);
			default: r = (b >= 16'd16) ? {16{a[15]}} : 16'($signed(a) >>> b[3:0]);
		endcase
		return r;
	endfunction

	function automatic logic [15:0] src_val(input logic [3:0] s, input logic [15:0] r5,
			input logic [15:0] rv);
		logic [15:0] v;
		if (s == 4'd0) begin
			v = 16'd0;
		end else if (s == {1'b0, REG_R}) begin
			v = r5;
		end else if (s[3] == 1'b0) begin
			v = rv;
		end else if (s == SRC_ONE) begin
			v = 16'd1;
		end else if (s == SRC_NEG_ONE) begin
			v = 16'hFFFF;
		end else begin
			v = 16'd0;
		end
		return v;
	endfunction

	assign tgt  = inst_q[15:13];
	assign opc  = inst_q[12:9];
	assign jbit = inst_q[8];
	assign status.is_inp = (opc == OP_INP);

	assign res    = alu(opc, op0_q, op1_q, rdata_q);
	assign stored = (tgt == REG_R) ? res : regs_q[REG_R];
	assign branch = jbit && (res != 16'd0) && (opc != OP_INP);

	always_comb begin
		unique case (cmd.sel)
			MA_PC:      rd_addr = pc_q;
			MA_LADDR:   rd_addr = item.load_address;
			MA_A:       rd_addr = regs_q[REG_A];
			default:    rd_addr = pc_q + 16'd1;
		endcase
	end

	always_comb begin
		wr_en   = cmd.load_wr || cmd.exec;
		wr_idx  = cmd.exec ? mem_index(regs_q[REG_A]) : mem_index(item.load_address);
		wr_data = cmd.exec ? stored : item.load_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[mem_index(rd_addr)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_inst) begin
			inst_q <= rdata_q;
		end
		if (cmd.latch_r) begin
			op0_q <= src_val(inst_q[7:4], rdata_q, regs_q[inst_q[6:4]]);
			op1_q <= src_val(inst_q[3:0], rdata_q, regs_q[inst_q[2:0]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 7; i++) begin
				regs_q[i] <= 16'd0;
			end
			pc_q     <= 16'd0;
			jt_q     <= 16'd0;
			wreg_q   <= 3'd0;
			wval_q   <= 16'd0;
			saddr_q  <= 16'd0;
			sdata_q  <= 16'd0;
			jtaken_q <= 1'b0;
		end else begin
			if (cmd.clear_out) begin
				wreg_q   <= 3'd0;
				wval_q   <= 16'd0;
				saddr_q  <= 16'd0;
				sdata_q  <= 16'd0;
				jtaken_q <= 1'b0;
			end
			if (cmd.set_pc) begin
				pc_q <= item.load_address;
			end
			if (cmd.latch_r) begin
				regs_q[REG_R] <= rdata_q;
			end
			if (cmd.step_pc) begin
				pc_q <= pc_q + 16'd1;
			end
			if (cmd.exec) begin
				if (tgt != REG_ZERO) begin
					regs_q[tgt] <= res;
				end
				if (!jbit && (tgt == REG_ZERO)) begin
					jt_q <= op0_q - 16'd1;
				end
				pc_q     <= branch ? jt_q : pc_q + 16'd1;
				wreg_q   <= tgt;
				wval_q   <= res;
				saddr_q  <= regs_q[REG_A];
				sdata_q  <= stored;
				jtaken_q <= branch;
			end
		end
	end

	assign result.next_pc          = pc_q;
	assign result.next_word        = rdata_q;
	assign result.written_register = wreg_q;
	assign result.written_value    = wval_q;
	assign result.store_address    = saddr_q;
	assign result.store_data       = sdata_q;
	assign result.jump_taken       = jtaken_q;

endmodule

>>> sv/sixteen_bit_register_cpu_step.sv
// Top level of the 16-bit register processor step block.
// Depends on sbrc_pkg, sbrc_ctrl and sbrc_dp.
//
// An item is taken when start is high and busy is low. Its result appears
// for one cycle with done high and must be taken then, since the receiver
// cannot stall the block. All work shares one single-port word memory, one
// access per cycle, and that port sets the rate. The instruction fetch is
// issued at the accepting edge. An execute item then steps through the data
// read of R, the immediate read for INP, ALU and write-back, the read of the
// next word, and the result. A load reads the word at the program counter
// and then shows the result. A program counter set or an ignored action
// goes straight to the result. A new item may be started in the cycle its
// predecessor's result is shown.
module sixteen_bit_register_cpu_step
	import sbrc_pkg::*;
#(
	parameter int MEM_WORDS = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  sbrc_in_t  item,
	output logic      done,
	output sbrc_out_t result
);

	sbrc_cmd_t    cmd;
	sbrc_status_t status;

	sbrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sbrc_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

>>> sv/sbrc_checker.sv
// Port-level checker of the 16-bit register processor step block, and the
// bind that attaches it to the top level. Depends on sbrc_pkg.
module sbrc_checker
	import sbrc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input sbrc_in_t  item,
	input logic      done,
	input sbrc_out_t result
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("A result beat was shown while the block was busy.");

	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_EXEC) |=> busy)
		else $error("An execute beat did not keep the block busy.");

	a_set_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_SET_PC)
		|=> done && (result.next_pc == $past(item.load_address)))
		else $error("A program counter set did not report the new counter.");

	a_load_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_LOAD) |=> busy ##1 done)
		else $error("A load beat did not finish in the expected cycles.");

	a_jump_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.jump_taken) |-> (result.written_value != 16'sd0))
		else $error("A jump was reported with a zero result.");

endmodule

bind sixteen_bit_register_cpu_step sbrc_checker u_sbrc_checker (.*);
